### rtl/bbp_pkg.sv
// Shared types and constants for the bimodal branch predictor.
`timescale 1ns / 1ps
package bbp_pkg;

    localparam int ADDR_W          = 32;
    localparam int CNT_W           = 8;
    localparam int CFG_W           = 4;
    localparam int TOTAL_W         = 32;
    localparam int MOD_STEPS       = 3;
    localparam int MOD_STEP_W      = 2;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam logic [CFG_W-1:0] CNT_BITS_RESET = CFG_W'(2);
    localparam logic [CFG_W-1:0] CNT_BITS_MIN   = CFG_W'(1);
    localparam logic [CFG_W-1:0] CNT_BITS_MAX   = CFG_W'(8);

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } bbp_item_t;

    typedef struct packed {
        logic               predicted_taken;
        logic               correct;
        logic [TOTAL_W-1:0] branch_count;
        logic [TOTAL_W-1:0] mispredict_count;
        logic [TOTAL_W-1:0] correct_count;
    } bbp_result_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic clear_step;
        logic update;
    } bbp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_last;
    } bbp_sts_t;

endpackage

### rtl/bimodal_branch_predictor.sv
// Top level of the bimodal branch predictor.
`timescale 1ns / 1ps
// Usage:
// A resolved branch (item: address and actual direction) is taken in as a
// transaction at a rising edge where start is high and busy is low.
// The result transaction (prediction, correctness and the three running
// totals) appears on result for exactly one cycle with done high. The
// receiver cannot stall, so it must capture result whenever done is high.
// The table index is the address modulo TABLE_ENTRIES. For a power-of-two
// table this is a bit slice and a branch passes through the accept cycle,
// the registered table read and the counter update and write-back; done
// follows in the next cycle, and a new branch can be accepted in that same
// cycle. For other table sizes a reciprocal multiplication unit first
// computes the remainder. The counter width register (cfg_we, cfg_data) is
// for the user to write only while idle; the block does not enforce it.
// After reset the table is cleared one entry per cycle while busy is high;
// totals restart at zero and the width is 2.
module bimodal_branch_predictor #(
    parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bbp_pkg::bbp_item_t        item,
    output logic                      done,
    output bbp_pkg::bbp_result_t      result,
    input  logic                      cfg_we,
    input  logic [bbp_pkg::CFG_W-1:0] cfg_data
);
    import bbp_pkg::*;

    bbp_cmd_t cmd;
    bbp_sts_t sts;

    bbp_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bbp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .result   (result),
        .done     (done)
    );

    // A result is only delivered once the sequencer is back in idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result delivered while busy");

    // An accepted transaction must make the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Every branch is either a correct prediction or a misprediction.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.branch_count ==
                  TOTAL_W'(result.mispredict_count + result.correct_count)))
        else $error("branch total does not match its parts");

    // One result per transaction: never two strobes in a row.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("back-to-back result strobes");

endmodule

### rtl/bbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bbp_ctrl.sv
// Control state machine that sequences table clearing, indexing and update.
`timescale 1ns / 1ps
module bbp_ctrl #(
    parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bbp_pkg::bbp_sts_t sts,
    output bbp_pkg::bbp_cmd_t cmd,
    output logic              busy
);
    import bbp_pkg::*;

    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = IS_POW2 ? ST_READ : ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/bbp_datapath.sv
// Datapath: index reduction, counter table, prediction, counter update and totals.
`timescale 1ns / 1ps
module bbp_datapath #(
    parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bbp_pkg::bbp_item_t        item,
    input  logic                      cfg_we,
    input  logic [bbp_pkg::CFG_W-1:0] cfg_data,
    input  bbp_pkg::bbp_cmd_t         cmd,
    output bbp_pkg::bbp_sts_t         sts,
    output bbp_pkg::bbp_result_t      result,
    output logic                      done
);
    import bbp_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] ENTRIES_LOW = IDX_W'(TABLE_ENTRIES);
    localparam int RECIP_SHIFT = ADDR_W + IDX_W;
    localparam int PLO_W  = ADDR_W + 16;
    localparam int PHI_W  = ADDR_W + 17;
    localparam int PROD_W = ADDR_W + 33;
    localparam logic [63:0] RECIP = ((64'd1 << RECIP_SHIFT) + 64'(TABLE_ENTRIES) - 64'd1)
                                    / 64'(TABLE_ENTRIES);
    localparam logic [15:0] RECIP_LO = RECIP[15:0];
    localparam logic [16:0] RECIP_HI = RECIP[32:16];

    logic [ADDR_W-1:0]     addr_reg;
    logic                  taken_reg;
    logic [IDX_W-1:0]      rem_reg;
    logic [MOD_STEP_W-1:0] step_reg;
    logic [PLO_W-1:0]      prod_lo_reg;
    logic [PHI_W-1:0]      prod_hi_reg;
    logic [IDX_W-1:0]      quo_reg;
    logic [IDX_W-1:0]      clr_idx_reg;
    logic [CFG_W-1:0]      cnt_bits_reg;
    logic [TOTAL_W-1:0]    branches_reg, mispredicts_reg, corrects_reg;
    bbp_result_t           result_reg;
    logic                  done_reg;

    logic [PROD_W-1:0] prod_sum;
    logic [IDX_W-1:0]  qn_low;
    logic [IDX_W-1:0]  rem_next;
    logic [IDX_W-1:0]  idx;
    logic [CFG_W-1:0]  width;
    logic [CNT_W-1:0]  half, maxv, cnt, cnt_next;
    logic              pred, ok;
    logic [TOTAL_W-1:0] branches_next, mispredicts_next, corrects_next;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;

    // Remainder by reciprocal multiplication: first two partial products, then the exact
    // quotient, then address minus quotient times table size. Only the low index bits of
    // the quotient and of the difference are needed.
    assign prod_sum = {17'b0, prod_lo_reg} + {prod_hi_reg, 16'b0};
    assign qn_low   = quo_reg * ENTRIES_LOW;
    assign rem_next = addr_reg[IDX_W-1:0] - qn_low;
    assign idx = IS_POW2 ? addr_reg[IDX_W-1:0] : rem_reg;

    assign sts.clear_last = (clr_idx_reg == LAST_IDX);
    assign sts.mod_last   = (step_reg == MOD_STEP_W'(MOD_STEPS - 1));

    // Effective counter width is clamped to 1..8.
    always_comb
    begin
        if (cnt_bits_reg < CNT_BITS_MIN)
        begin
            width = CNT_BITS_MIN;
        end
        else if (cnt_bits_reg > CNT_BITS_MAX)
        begin
            width = CNT_BITS_MAX;
        end
        else
        begin
            width = cnt_bits_reg;
        end
    end

    assign half = CNT_W'(1) << (width - CFG_W'(1));
    assign maxv = {CNT_W{1'b1}} >> (CFG_W'(CNT_W) - width);
    assign pred = (cnt >= half);
    assign ok   = (pred == taken_reg);

    // A counter above the current maximum snaps to the maximum on a taken branch.
    always_comb
    begin
        if (taken_reg)
        begin
            cnt_next = (cnt < maxv) ? cnt + CNT_W'(1) : maxv;
        end
        else
        begin
            cnt_next = (cnt != '0) ? cnt - CNT_W'(1) : cnt;
        end
    end

    assign branches_next    = branches_reg + TOTAL_W'(1);
    assign mispredicts_next = ok ? mispredicts_reg : mispredicts_reg + TOTAL_W'(1);
    assign corrects_next    = ok ? corrects_reg + TOTAL_W'(1) : corrects_reg;

    assign ram_we    = cmd.clear_step | cmd.update;
    assign ram_waddr = cmd.clear_step ? clr_idx_reg : idx;
    assign ram_wdata = cmd.clear_step ? '0 : cnt_next;

    bbp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx),
        .rdata (cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg     <= '0;
            cnt_bits_reg    <= CNT_BITS_RESET;
            branches_reg    <= '0;
            mispredicts_reg <= '0;
            corrects_reg    <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cfg_we)
            begin
                cnt_bits_reg <= cfg_data;
            end
            if (cmd.update)
            begin
                branches_reg    <= branches_next;
                mispredicts_reg <= mispredicts_next;
                corrects_reg    <= corrects_next;
            end
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg  <= item.branch_address;
            taken_reg <= item.taken;
            step_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            prod_lo_reg <= PLO_W'(addr_reg) * PLO_W'(RECIP_LO);
            prod_hi_reg <= PHI_W'(addr_reg) * PHI_W'(RECIP_HI);
            quo_reg     <= prod_sum[RECIP_SHIFT +: IDX_W];
            rem_reg     <= rem_next;
            step_reg    <= step_reg + MOD_STEP_W'(1);
        end
        if (cmd.update)
        begin
            result_reg.predicted_taken  <= pred;
            result_reg.correct          <= ok;
            result_reg.branch_count     <= branches_next;
            result_reg.mispredict_count <= mispredicts_next;
            result_reg.correct_count    <= corrects_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
